// File: hdl/tcrq_pkg.sv
// Shared types and command/status codes for the tagged commit ring queue.
package tcrq_pkg;

  // ring capacity; pointers wrap at 2*DEPTH, so it must be a power of two
  localparam int DEPTH = 64;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_ACK    = 3'd1;
  localparam logic [2:0] CMD_DONE   = 3'd2;
  localparam logic [2:0] CMD_RETIRE = 3'd3;
  localparam logic [2:0] CMD_MAXACK = 3'd4;
  localparam logic [2:0] CMD_TRUNC  = 3'd5;
  localparam logic [2:0] CMD_PEEK   = 3'd6;
  localparam logic [2:0] CMD_NOP    = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] xid;
  } cmd_t;

endpackage

// File: hdl/tcrq_cmd_fifo.sv
// Short command queue between the input front end and the execution engine.
module tcrq_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  tcrq_pkg::cmd_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output tcrq_pkg::cmd_t  rd_data
);

  tcrq_pkg::cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end

endmodule

// File: hdl/tcrq_engine.sv
// Execution engine: ring storage, sequential scans, result register.
module tcrq_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  tcrq_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [1:0]      res_status,
  output logic [63:0]     res_value,
  output logic [6:0]      res_count,
  output logic [6:0]      res_occupancy
);

  localparam int DEPTH = tcrq_pkg::DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;  // read issued, data next cycle
  localparam logic [2:0] S_CHK  = 3'd2;  // data in rdata_r
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0]    st_r;
  logic [PW-1:0] head_r, tail_r, k_r;
  logic [DEPTH-1:0] ack_r, done_r;
  logic [63:0]   ids [DEPTH];
  logic [63:0]   rdata_r;
  logic [AW-1:0] rslot_r;
  logic [2:0]    op_r;
  logic [63:0]   x_r, val_r;
  logic [1:0]    stat_r;
  logic [PW-1:0] cnt_r;
  logic          out_v_r;

  logic [PW-1:0] occ, idx;
  logic [AW-1:0] slot;
  assign occ  = head_r - tail_r;
  assign idx  = tail_r + k_r;
  assign slot = idx[AW-1:0];

  assign cmd_ready     = (st_r == S_IDLE) && !out_v_r;
  assign res_valid     = out_v_r;
  assign res_status    = stat_r;
  assign res_value     = val_r;
  assign res_count     = 7'(cnt_r);
  assign res_occupancy = 7'(occ);

  logic wr_en;
  logic [AW-1:0] wr_slot;
  assign wr_en   = cmd_valid && cmd_ready && cmd.command == tcrq_pkg::CMD_ADD
                   && occ != PW'(DEPTH);
  assign wr_slot = head_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) ids[wr_slot] <= cmd.xid;
    rdata_r <= ids[slot];
    rslot_r <= slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; head_r <= '0; tail_r <= '0; k_r <= '0;
      ack_r <= '0; done_r <= '0; out_v_r <= 1'b0;
      stat_r <= '0; val_r <= '0; cnt_r <= '0; op_r <= '0; x_r <= '0;
    end else begin
      if (out_v_r && res_ready) out_v_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            op_r <= cmd.command; x_r <= cmd.xid; k_r <= '0;
            stat_r <= tcrq_pkg::ST_OK; val_r <= '0; cnt_r <= '0;
            case (cmd.command)
              tcrq_pkg::CMD_ADD: begin
                if (occ == PW'(DEPTH)) stat_r <= tcrq_pkg::ST_FULL;
                else begin
                  head_r <= head_r + 1'b1;
                  ack_r[wr_slot] <= 1'b0;
                  done_r[wr_slot] <= 1'b0;
                end
                out_v_r <= 1'b1;
              end
              tcrq_pkg::CMD_ACK, tcrq_pkg::CMD_DONE, tcrq_pkg::CMD_MAXACK,
              tcrq_pkg::CMD_TRUNC: begin
                if (cmd.command == tcrq_pkg::CMD_MAXACK) val_r <= cmd.xid;
                if (occ == '0) begin
                  if (cmd.command == tcrq_pkg::CMD_ACK ||
                      cmd.command == tcrq_pkg::CMD_DONE)
                    stat_r <= tcrq_pkg::ST_NOTFOUND;
                  out_v_r <= 1'b1;
                end else st_r <= S_RD;
              end
              tcrq_pkg::CMD_RETIRE: st_r <= S_DONE;
              tcrq_pkg::CMD_PEEK: begin
                if (occ == '0) begin
                  stat_r <= tcrq_pkg::ST_EMPTY;
                  out_v_r <= 1'b1;
                end else st_r <= S_RD;
              end
              default: out_v_r <= 1'b1;
            endcase
          end
        end
        S_RD: st_r <= S_CHK;
        S_CHK: begin
          st_r <= S_RD;
          k_r  <= k_r + 1'b1;
          case (op_r)
            tcrq_pkg::CMD_PEEK: begin
              val_r <= rdata_r; st_r <= S_IDLE; out_v_r <= 1'b1;
            end
            tcrq_pkg::CMD_ACK, tcrq_pkg::CMD_DONE: begin
              if (rdata_r == x_r) begin
                if (op_r == tcrq_pkg::CMD_ACK) ack_r[rslot_r] <= 1'b1;
                else done_r[rslot_r] <= 1'b1;
                st_r <= S_IDLE; out_v_r <= 1'b1;
              end else if (k_r + 1'b1 == occ) begin
                stat_r <= tcrq_pkg::ST_NOTFOUND;
                st_r <= S_IDLE; out_v_r <= 1'b1;
              end
            end
            tcrq_pkg::CMD_MAXACK: begin
              if (ack_r[rslot_r] && rdata_r > val_r) val_r <= rdata_r;
              if (k_r + 1'b1 == occ) begin
                st_r <= S_IDLE; out_v_r <= 1'b1;
              end
            end
            tcrq_pkg::CMD_TRUNC: begin
              if (rdata_r > x_r) begin
                cnt_r  <= occ - k_r;
                head_r <= tail_r + k_r;
                st_r <= S_IDLE; out_v_r <= 1'b1;
              end else if (k_r + 1'b1 == occ) begin
                st_r <= S_IDLE; out_v_r <= 1'b1;
              end
            end
            default: begin
              st_r <= S_IDLE; out_v_r <= 1'b1;
            end
          endcase
        end
        S_DONE: begin
          // retire one done entry per cycle from the tail
          if (occ != '0 && done_r[tail_r[AW-1:0]]) begin
            done_r[tail_r[AW-1:0]] <= 1'b0;
            tail_r <= tail_r + 1'b1;
            cnt_r  <= cnt_r + 1'b1;
          end else begin
            st_r <= S_IDLE; out_v_r <= 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/tagged_commit_ring_queue_unit.sv
// Top level of the tagged commit ring queue.
// Input beats carry a command and a 64-bit id; each produces exactly one
// result beat with status, value, count and occupancy after the command.
// A two-entry command queue decouples the input from the execution engine,
// so up to two commands are taken while the engine is busy or the output
// register waits on out_tready.
// Add and unknown commands, and all but retire on an empty queue, go straight
// to the result register. Peek reads the tail id, then returns it; mark,
// max-acked and truncate read the stored ids one by one from the tail, each
// read then checked; retire frees done entries from the tail until one is
// not done. The engine takes its next command the cycle after the result
// beat is taken, so it executes one command at a time.
// Reset clears both pointers and all marks; the queue is empty. Stored ids
// are written by add only. When the receiver stalls the result register
// holds, the engine stops after it, and the input stalls once the command
// queue is full.
module tagged_commit_ring_queue_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // command[2:0], xid[66:3], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata   // status[1:0], value[65:2], count[72:66], occupancy[79:73]
);

  tcrq_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [1:0]  st;
  logic [63:0] val;
  logic [6:0]  cnt, occ;

  assign in_cmd.command = in_tdata[2:0];
  assign in_cmd.xid     = in_tdata[66:3];

  tcrq_cmd_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_data(in_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  tcrq_engine u_eng (
    .clk, .rst_n,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_status(st), .res_value(val), .res_count(cnt), .res_occupancy(occ)
  );

  assign out_tdata = {occ, cnt, val, st};

endmodule

// File: hdl/tcrq_checker.sv
// Port-level checker for the tagged commit ring queue, bound to the top level.
module tcrq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[79:73] <= 7'd64)
    else $error("occupancy out of range");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == tcrq_pkg::ST_FULL |-> out_tdata[79:73] == 7'd64)
    else $error("full reported below capacity");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind tagged_commit_ring_queue_unit tcrq_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);

// File: bench/tb_tagged_commit_ring_queue_unit.sv
// Self-checking testbench for the tagged commit ring queue unit.
module tb_tagged_commit_ring_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = tcrq_pkg::DEPTH;
  localparam int WATCHDOG_LIMIT = 20000;

  // first member lands in the top bits, matching the out_tdata packing
  typedef struct packed {
    logic [6:0]  occupancy;
    logic [6:0]  count;
    logic [63:0] value;
    logic [1:0]  status;
  } qres_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  tagged_commit_ring_queue_unit DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow queue state
  logic [63:0] shadow_ids [QDEPTH];
  logic        shadow_ack [QDEPTH];
  logic        shadow_done [QDEPTH];
  logic [7:0]  head_ptr = 8'd0;
  logic [7:0]  tail_ptr = 8'd0;
  qres_t       pending_results [$];
  int          fail_count = 0;
  int          idle_pct = 30;
  int          stall_pct = 30;
  int          idle_cycles = 0;
  logic [63:0] live_ids [$];

  function automatic int shadow_occ();
    return int'(8'(head_ptr - tail_ptr) % 8'(2 * QDEPTH));
  endfunction

  function automatic int slot_of(int k);
    return int'((tail_ptr + 8'(k)) % 8'(2 * QDEPTH)) % QDEPTH;
  endfunction

  // compute the expected result of one command and update the shadow state
  function automatic qres_t queue_predict(logic [2:0] op, logic [63:0] xid);
    qres_t r;
    int n, s, k;
    r = '0;
    n = shadow_occ();
    s = QDEPTH;
    case (op)
      tcrq_pkg::CMD_ADD: begin
        if (n >= QDEPTH) r.status = tcrq_pkg::ST_FULL;
        else begin
          s = int'(head_ptr) % QDEPTH;
          shadow_ids[s] = xid;
          shadow_ack[s] = 1'b0;
          shadow_done[s] = 1'b0;
          head_ptr = (head_ptr + 8'd1) % 8'(2 * QDEPTH);
        end
      end
      tcrq_pkg::CMD_ACK, tcrq_pkg::CMD_DONE: begin
        for (k = 0; k < n; k++)
          if (shadow_ids[slot_of(k)] == xid) begin
            s = slot_of(k);
            break;
          end
        if (s == QDEPTH) r.status = tcrq_pkg::ST_NOTFOUND;
        else if (op == tcrq_pkg::CMD_ACK) shadow_ack[s] = 1'b1;
        else shadow_done[s] = 1'b1;
      end
      tcrq_pkg::CMD_RETIRE: begin
        while (shadow_occ() != 0 && shadow_done[int'(tail_ptr) % QDEPTH]) begin
          shadow_done[int'(tail_ptr) % QDEPTH] = 1'b0;
          tail_ptr = (tail_ptr + 8'd1) % 8'(2 * QDEPTH);
          r.count++;
        end
      end
      tcrq_pkg::CMD_MAXACK: begin
        r.value = xid;
        for (k = 0; k < n; k++)
          if (shadow_ack[slot_of(k)] && shadow_ids[slot_of(k)] > r.value)
            r.value = shadow_ids[slot_of(k)];
      end
      tcrq_pkg::CMD_TRUNC: begin
        for (k = 0; k < n; k++)
          if (shadow_ids[slot_of(k)] > xid) begin
            r.count = 7'(n - k);
            head_ptr = (tail_ptr + 8'(k)) % 8'(2 * QDEPTH);
            break;
          end
      end
      tcrq_pkg::CMD_PEEK: begin
        if (n == 0) r.status = tcrq_pkg::ST_EMPTY;
        else r.value = shadow_ids[int'(tail_ptr) % QDEPTH];
      end
      default: ;
    endcase
    r.occupancy = 7'(shadow_occ());
    return r;
  endfunction

  // valid stays high between back-to-back beats; it drops only while idling or draining
  task automatic send_cmd(logic [2:0] op, logic [63:0] xid);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {5'd0, xid, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(queue_predict(op, xid));
    if (op == tcrq_pkg::CMD_ADD) live_ids.push_back(xid);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4 * QDEPTH + 8) @(negedge clk);
  endtask

  // pick an id likely present in the queue
  function automatic logic [63:0] known_id();
    if (live_ids.size() == 0 || $urandom_range(9) == 0)
      return {$urandom, $urandom};
    return live_ids[$urandom_range(live_ids.size() - 1)];
  endfunction

  task automatic test_edge_cases();
    send_cmd(tcrq_pkg::CMD_PEEK, 64'd0);
    send_cmd(tcrq_pkg::CMD_ACK, 64'd5);
    send_cmd(tcrq_pkg::CMD_DONE, 64'd5);
    send_cmd(tcrq_pkg::CMD_RETIRE, 64'd0);
    send_cmd(tcrq_pkg::CMD_TRUNC, 64'd0);
    send_cmd(tcrq_pkg::CMD_MAXACK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(tcrq_pkg::CMD_NOP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(tcrq_pkg::CMD_ADD, 64'd0);
    send_cmd(tcrq_pkg::CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(tcrq_pkg::CMD_ADD, 64'h5555_5555_5555_5555);
    send_cmd(tcrq_pkg::CMD_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_cmd(tcrq_pkg::CMD_ADD, 64'd0);
    send_cmd(tcrq_pkg::CMD_PEEK, 64'd0);
    send_cmd(tcrq_pkg::CMD_ACK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(tcrq_pkg::CMD_ACK, 64'h5555_5555_5555_5555);
    send_cmd(tcrq_pkg::CMD_MAXACK, 64'd0);
    send_cmd(tcrq_pkg::CMD_MAXACK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(tcrq_pkg::CMD_DONE, 64'd0);
    send_cmd(tcrq_pkg::CMD_RETIRE, 64'd0);
    send_cmd(tcrq_pkg::CMD_DONE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(tcrq_pkg::CMD_RETIRE, 64'd0);
    send_cmd(tcrq_pkg::CMD_TRUNC, 64'h6000_0000_0000_0000);
    send_cmd(tcrq_pkg::CMD_TRUNC, 64'd0);
    send_cmd(tcrq_pkg::CMD_ADD, 64'h1234);
    send_cmd(tcrq_pkg::CMD_PEEK, 64'd0);
  endtask

  // fill past full, then send done for each added id and retire twice
  task automatic test_full_queue();
    for (int i = 0; i < QDEPTH + 2; i++)
      send_cmd(tcrq_pkg::CMD_ADD, 64'(i) << 56 | 64'(i));
    for (int i = 0; i < QDEPTH; i++)
      send_cmd(tcrq_pkg::CMD_DONE, 64'(i) << 56 | 64'(i));
    send_cmd(tcrq_pkg::CMD_RETIRE, 64'd0);
    send_cmd(tcrq_pkg::CMD_RETIRE, 64'd0);
    drain_results();
  endtask

  task automatic test_random_traffic(int n_items);
    logic [2:0] op;
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) op = tcrq_pkg::CMD_ADD;
      else if (pick < 50) op = tcrq_pkg::CMD_ACK;
      else if (pick < 68) op = tcrq_pkg::CMD_DONE;
      else if (pick < 80) op = tcrq_pkg::CMD_RETIRE;
      else if (pick < 87) op = tcrq_pkg::CMD_MAXACK;
      else if (pick < 91) op = tcrq_pkg::CMD_TRUNC;
      else if (pick < 97) op = tcrq_pkg::CMD_PEEK;
      else op = tcrq_pkg::CMD_NOP;
      if (op == tcrq_pkg::CMD_ADD)
        send_cmd(op, $urandom_range(3) == 0 ? {$urandom, $urandom}
                                            : known_id() ^ 64'($urandom_range(3)));
      else if (op == tcrq_pkg::CMD_TRUNC && $urandom_range(1))
        send_cmd(op, 64'hFFFF_FFFF_FFFF_FFFF >> $urandom_range(63));
      else send_cmd(op, known_id());
      if (live_ids.size() > 200) void'(live_ids.pop_front());
    end
  endtask

  // result checker
  always @(posedge clk) begin
    qres_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status) begin
          $error("status exp %0d got %0d", exp.status, got.status); fail_count++;
        end
        if (got.value !== exp.value) begin
          $error("value exp %h got %h", exp.value, got.value); fail_count++;
        end
        if (got.count !== exp.count) begin
          $error("count exp %0d got %0d", exp.count, got.count); fail_count++;
        end
        if (got.occupancy !== exp.occupancy) begin
          $error("occupancy exp %0d got %0d", exp.occupancy, got.occupancy); fail_count++;
        end
      end
    end
  end

  always @(negedge clk)
    out_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_edge_cases();
    drain_results();
    test_full_queue();
    test_random_traffic(200);
    // no idling on either side for a stretch
    idle_pct = 0;
    stall_pct = 0;
    test_random_traffic(150);
    idle_pct = 30;
    stall_pct = 30;
    drain_results();
    test_random_traffic(200);
    drain_results();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/tcrq_pkg.sv
hdl/tcrq_cmd_fifo.sv
hdl/tcrq_engine.sv
hdl/tagged_commit_ring_queue_unit.sv
hdl/tcrq_checker.sv
bench/tb_tagged_commit_ring_queue_unit.sv
